[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, muted while reset is high.
`define JSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jse: assertion failed");

// Same, on the block's own clock and reset names.
`define JSE_ASSERT_CLK(label, prop) `JSE_ASSERT(label, clock, reset, prop)

`endif

[src/jse_pkg.sv]
`default_nettype none

package jse_pkg;

   localparam logic [7:0]  CHAR_QUOTE  = 8'h22;
   localparam logic [7:0]  CHAR_BSLASH = 8'h5c;
   localparam logic [7:0]  CHAR_U      = 8'h75;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
   localparam logic [7:0]  HIGH_BYTE   = 8'h80;
   localparam logic [12:0] STR_LIMIT   = 13'd4096;
   localparam logic [11:0] MAX_RESET   = 12'd4095;

   // Token kinds produced by the classifier and replayed by the sequencer
   typedef enum logic [2:0] {
      TOK_PLAIN,
      TOK_ESC2,
      TOK_HEX,
      TOK_COPY,
      TOK_HOLD,
      TOK_DONE,
      TOK_OPEN,
      TOK_CLOSE
   } jse_tok_type;

   typedef struct packed {
      jse_tok_type kind;
      logic [2:0]  len;
   } jse_class_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'h30 + {4'h0, v};
      end else begin
         r = 8'h57 + {4'h0, v};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[src/jse_req_if.sv]
`default_nettype none

interface jse_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

[src/jse_rsp_if.sv]
`default_nettype none

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_end;
   logic       too_long;

   modport source (output valid, output out_byte, output run_last, output string_end,
                   output too_long, input ready);
   modport sink   (input valid, input out_byte, input run_last, input string_end,
                   input too_long, output ready);
endinterface

`default_nettype wire

[src/json_string_escaper_utf8.sv]
// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+-----------------------------------------------
// req     | in  | valid/ready        | action, data_byte
// rsp     | out | valid/ready        | out_byte, run_last, string_end, too_long
// csr     | in  | csr_we, no wait    | csr_wdata = max_string_bytes
//
// One item at a time: an accept step, a classify step per token plus one that finds
// the window empty and either ends the item or picks the closing quote (the opening
// quote needs none) or that parks an incomplete sequence, an emit step per byte and
// a closing step. The classifier is the one shared unit.
// Synchronous active-high reset; max_string_bytes resets to 4095.
// A stalled rsp holds the staged byte and freezes the sequencer.
`default_nettype none

module json_string_escaper_utf8 import jse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   jse_req_if.sink     req,
   jse_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [11:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CLASSIFY,
      S_EMIT,
      S_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [11:0]     max_ff, max_in;
   logic            in_string_ff, in_string_in;
   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      held_count_ff, held_count_in;
   logic [12:0]     byte_count_ff, byte_count_in;
   logic            ovf_ff, ovf_in;

   // Work window: held bytes plus the new one
   logic [3:0][7:0] win_ff, win_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            flush_ff, flush_in;

   // Current token
   jse_tok_type     tok_ff, tok_in;
   logic [2:0]      tok_len_ff, tok_len_in;
   logic [2:0]      idx_ff, idx_in;

   // Staged result, held back until we know whether another follows
   logic            stage_v_ff, stage_v_in;
   logic [7:0]      stage_byte_ff, stage_byte_in;
   logic            stage_end_ff, stage_end_in;
   logic            stage_tl_ff, stage_tl_in;

   // Output register
   logic            rsp_v_ff, rsp_v_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_end_ff, rsp_end_in;
   logic            rsp_tl_ff, rsp_tl_in;

   jse_class_type   cls;
   logic            push_ok;
   logic            produce_ok;
   logic [7:0]      emit_byte;
   logic [2:0]      emit_count;
   logic [2:0]      consume;
   logic [12:0]     base_count;
   logic            base_ovf;
   logic [12:0]     next_count;

   jse_classify u_classify (
      .win   (win_ff),
      .cnt   (cnt_ff),
      .flush (flush_ff),
      .cls   (cls)
   );

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_v_ff;
   assign rsp.out_byte   = rsp_byte_ff;
   assign rsp.run_last   = rsp_last_ff;
   assign rsp.string_end = rsp_end_ff;
   assign rsp.too_long   = rsp_tl_ff;

   assign push_ok    = !rsp_v_ff || rsp.ready;
   assign produce_ok = !stage_v_ff || push_ok;

   // A new string restarts the length count
   assign base_count = in_string_ff ? byte_count_ff : 13'd0;
   assign base_ovf   = in_string_ff ? ovf_ff : 1'b0;
   assign next_count = (base_count < STR_LIMIT) ? base_count + 13'd1 : base_count;

   // Byte of the current token at position idx
   always_comb begin
      emit_byte = win_ff[0];
      case (tok_ff)
         TOK_OPEN, TOK_CLOSE: emit_byte = CHAR_QUOTE;
         TOK_PLAIN:           emit_byte = win_ff[0];
         TOK_ESC2:            emit_byte = (idx_ff == 3'd0) ? CHAR_BSLASH : win_ff[0];
         TOK_COPY:            emit_byte = win_ff[idx_ff[1:0]];
         TOK_HEX: begin
            case (idx_ff)
               3'd0:    emit_byte = CHAR_BSLASH;
               3'd1:    emit_byte = CHAR_U;
               3'd2:    emit_byte = CHAR_ZERO;
               3'd3:    emit_byte = CHAR_ZERO;
               3'd4:    emit_byte = hex_char(win_ff[0][7:4]);
               default: emit_byte = hex_char(win_ff[0][3:0]);
            endcase
         end
         default:             emit_byte = win_ff[0];
      endcase
   end

   always_comb begin
      case (tok_ff)
         TOK_ESC2: emit_count = 3'd2;
         TOK_HEX:  emit_count = 3'd6;
         TOK_COPY: emit_count = tok_len_ff;
         default:  emit_count = 3'd1;
      endcase
   end

   always_comb begin
      case (tok_ff)
         TOK_OPEN, TOK_CLOSE: consume = 3'd0;
         TOK_COPY:            consume = tok_len_ff;
         default:             consume = 3'd1;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      max_in        = max_ff;
      in_string_in  = in_string_ff;
      held_in       = held_ff;
      held_count_in = held_count_ff;
      byte_count_in = byte_count_ff;
      ovf_in        = ovf_ff;
      win_in        = win_ff;
      cnt_in        = cnt_ff;
      flush_in      = flush_ff;
      tok_in        = tok_ff;
      tok_len_in    = tok_len_ff;
      idx_in        = idx_ff;
      stage_v_in    = stage_v_ff;
      stage_byte_in = stage_byte_ff;
      stage_end_in  = stage_end_ff;
      stage_tl_in   = stage_tl_ff;
      rsp_v_in      = push_ok ? 1'b0 : rsp_v_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_tl_in     = rsp_tl_ff;

      if (csr_we) begin
         max_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               // Load the window: held bytes first, then the new byte
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < held_count_ff) begin
                     win_in[i] = held_ff[i];
                  end else begin
                     win_in[i] = req.data_byte;
                  end
               end
               win_in[3]     = req.data_byte;
               cnt_in        = {1'b0, held_count_ff} + {2'b00, !req.action};
               flush_in      = req.action;
               held_count_in = 2'd0;
               byte_count_in = base_count;
               ovf_in        = base_ovf;
               if (!req.action) begin
                  byte_count_in = next_count;
                  ovf_in        = base_ovf || (next_count > {1'b0, max_ff});
               end
               idx_in = 3'd0;
               if (!in_string_ff) begin
                  in_string_in = 1'b1;
                  tok_in       = TOK_OPEN;
                  state_in     = S_EMIT;
               end else begin
                  state_in = S_CLASSIFY;
               end
            end
         end

         S_CLASSIFY: begin
            idx_in     = 3'd0;
            tok_in     = cls.kind;
            tok_len_in = cls.len;
            if (cls.kind == TOK_DONE) begin
               state_in = S_FINISH;
            end else if (cls.kind == TOK_HOLD) begin
               // Park the undecided sequence for the next item
               held_in       = win_ff[2:0];
               held_count_in = cnt_ff[1:0];
               state_in      = S_FINISH;
            end else begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (produce_ok) begin
               // Advance the staged byte to the output, stage the new one
               if (stage_v_ff) begin
                  rsp_v_in    = 1'b1;
                  rsp_byte_in = stage_byte_ff;
                  rsp_last_in = 1'b0;
                  rsp_end_in  = stage_end_ff;
                  rsp_tl_in   = stage_tl_ff;
               end
               stage_v_in    = 1'b1;
               stage_byte_in = emit_byte;
               stage_end_in  = (tok_ff == TOK_CLOSE);
               stage_tl_in   = (tok_ff == TOK_CLOSE) && ovf_ff;
               if (idx_ff == emit_count - 3'd1) begin
                  // Drop the consumed bytes from the window
                  for (int i = 0; i < 4; i++) begin
                     if (3'(i) + consume < 3'd4) begin
                        win_in[i] = win_ff[2'(3'(i) + consume)];
                     end
                  end
                  cnt_in = cnt_ff - consume;
                  if (tok_ff == TOK_CLOSE) begin
                     in_string_in  = 1'b0;
                     held_count_in = 2'd0;
                     byte_count_in = 13'd0;
                     ovf_in        = 1'b0;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_CLASSIFY;
                  end
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end

         S_FINISH: begin
            // Release the last staged byte of the item, marked as last
            if (!stage_v_ff) begin
               state_in = S_IDLE;
            end else if (push_ok) begin
               rsp_v_in    = 1'b1;
               rsp_byte_in = stage_byte_ff;
               rsp_last_in = 1'b1;
               rsp_end_in  = stage_end_ff;
               rsp_tl_in   = stage_tl_ff;
               stage_v_in  = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_ff        <= MAX_RESET;
         in_string_ff  <= 1'b0;
         held_count_ff <= 2'd0;
         byte_count_ff <= 13'd0;
         ovf_ff        <= 1'b0;
         stage_v_ff    <= 1'b0;
         rsp_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_ff        <= max_in;
         in_string_ff  <= in_string_in;
         held_count_ff <= held_count_in;
         byte_count_ff <= byte_count_in;
         ovf_ff        <= ovf_in;
         stage_v_ff    <= stage_v_in;
         rsp_v_ff      <= rsp_v_in;
      end
      held_ff       <= held_in;
      win_ff        <= win_in;
      cnt_ff        <= cnt_in;
      flush_ff      <= flush_in;
      tok_ff        <= tok_in;
      tok_len_ff    <= tok_len_in;
      idx_ff        <= idx_in;
      stage_byte_ff <= stage_byte_in;
      stage_end_ff  <= stage_end_in;
      stage_tl_ff   <= stage_tl_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_tl_ff     <= rsp_tl_in;
   end

endmodule

`default_nettype wire

[src/jse_classify.sv]
`default_nettype none

module jse_classify import jse_pkg::*; (
   input  logic [3:0][7:0] win,
   input  logic [2:0]      cnt,
   input  logic            flush,
   output jse_class_type   cls
);

   logic [7:0] lead;
   logic [2:0] need;
   logic [2:0] lim;
   logic       bad;
   logic       partial;
   logic [7:0] lo;
   logic [7:0] hi;

   assign lead = win[0];

   always_comb begin
      if (lead inside {[8'hc2:8'hdf]}) begin
         need = 3'd2;
      end else if (lead inside {[8'he0:8'hef]}) begin
         need = 3'd3;
      end else if (lead inside {[8'hf0:8'hf4]}) begin
         need = 3'd4;
      end else begin
         need = 3'd0;
      end
   end

   assign lim     = (cnt < need) ? cnt : need;
   assign partial = cnt < need;

   // Range-check the continuation bytes present in the window
   always_comb begin
      bad = 1'b0;
      lo  = 8'h80;
      hi  = 8'hbf;
      for (int i = 1; i < 4; i++) begin
         lo = 8'h80;
         hi = 8'hbf;
         if (i == 1) begin
            if (lead == 8'he0) begin
               lo = 8'ha0;
            end else if (lead == 8'hed) begin
               hi = 8'h9f;
            end else if (lead == 8'hf0) begin
               lo = 8'h90;
            end else if (lead == 8'hf4) begin
               hi = 8'h8f;
            end
         end
         if (3'(i) < lim && (win[i] < lo || win[i] > hi)) begin
            bad = 1'b1;
         end
      end
   end

   always_comb begin
      cls.kind = TOK_DONE;
      cls.len  = 3'd1;
      if (cnt == 3'd0) begin
         cls.kind = flush ? TOK_CLOSE : TOK_DONE;
      end else if (lead < HIGH_BYTE) begin
         if (lead == CHAR_QUOTE || lead == CHAR_BSLASH) begin
            cls.kind = TOK_ESC2;
         end else if (lead < CTRL_LIMIT) begin
            cls.kind = TOK_HEX;
         end else begin
            cls.kind = TOK_PLAIN;
         end
      end else if (need == 3'd0 || bad) begin
         cls.kind = TOK_HEX;
      end else if (partial) begin
         cls.kind = flush ? TOK_HEX : TOK_HOLD;
      end else begin
         cls.kind = TOK_COPY;
         cls.len  = need;
      end
   end

endmodule

`default_nettype wire

[src/jse_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module jse_checker import jse_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_run_last,
   input wire logic       rsp_string_end,
   input wire logic       rsp_too_long
);

   logic [10:0] rsp_word;

   assign rsp_word = {rsp_out_byte, rsp_run_last, rsp_string_end, rsp_too_long};

   // The closing quote always ends the run of its item
   `JSE_ASSERT_CLK(a_end_is_last, rsp_valid && rsp_string_end |-> rsp_run_last)
   `JSE_ASSERT_CLK(a_end_quote, rsp_valid && rsp_string_end |-> rsp_out_byte == CHAR_QUOTE)

   // The length flag only rides on the closing quote
   `JSE_ASSERT_CLK(a_too_long_on_end, rsp_valid && rsp_too_long |-> rsp_string_end)

   // One item in work at a time
   `JSE_ASSERT_CLK(a_busy_after_accept, req_valid && req_ready |=> !req_ready)

   // Hold a stalled result
   `JSE_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))

endmodule

bind json_string_escaper_utf8 jse_checker u_jse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_out_byte   (rsp.out_byte),
   .rsp_run_last   (rsp.run_last),
   .rsp_string_end (rsp.string_end),
   .rsp_too_long   (rsp.too_long)
);

`default_nettype wire
